// ===== rtl/csbd_pkg.sv =====
`timescale 1ns / 1ps

package csbd_pkg;

  localparam int ModeBits = 7;
  localparam int PageBits = 6;

  localparam logic [1:0] CMD_BUS_WRITE = 2'd0;
  localparam logic [1:0] CMD_BUS_READ  = 2'd1;
  localparam logic [1:0] CMD_PRELOAD   = 2'd2;
  localparam logic [1:0] CMD_SAVED     = 2'd3;

  localparam logic [1:0] PORT_LOW  = 2'd0;
  localparam logic [1:0] PORT_MID  = 2'd1;
  localparam logic [1:0] PORT_DATA = 2'd2;
  localparam logic [1:0] PORT_MODE = 2'd3;

  localparam logic [1:0] SEL_PACK_A = 2'd0;
  localparam logic [1:0] SEL_PACK_B = 2'd1;
  localparam logic [1:0] SEL_ROM    = 2'd2;

  localparam logic [ModeBits-1:0] MODE_JOYSTICK = 7'd1;
  localparam logic [ModeBits-1:0] MODE_ROM      = 7'd2;
  localparam logic [ModeBits-1:0] MODE_PACK_B   = 7'd3;
  localparam logic [ModeBits-1:0] MODE_PACK_A   = 7'd4;
  localparam logic [ModeBits-1:0] MODE_CONTROL  = 7'd5;

  localparam logic CFG_SLOT4_PAGE = 1'b0;
  localparam logic CFG_SLOT3_PAGE = 1'b1;

  localparam logic [7:0] BYTE_IDLE = 8'hff;

  typedef enum logic [2:0] {
    SRC_IMM,
    SRC_ROM,
    SRC_PACK_A,
    SRC_PACK_B,
    SRC_DIRTY
  } src_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  port;
    logic [7:0]  data;
    logic [1:0]  store_select;
    logic [16:0] load_index;
    logic [7:0]  joystick;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       page_request_valid;
    logic       page_request_slot;
    logic [7:0] page_request_page;
  } out_item_t;

endpackage

// ===== rtl/csbd_in_if.sv =====
`timescale 1ns / 1ps

interface csbd_in_if;
  logic                valid;
  logic                ready;
  csbd_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/csbd_out_if.sv =====
`timescale 1ns / 1ps

interface csbd_out_if;
  logic                valid;
  logic                ready;
  csbd_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/csbd_ram.sv =====
`timescale 1ns / 1ps

module csbd_ram #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [7:0]           wdata,
  output logic [7:0]           rdata
);

  logic [7:0] mem [2**ADDR_BITS];

  // read-first: rdata carries the byte held before this write
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/cartridge_slot_bank_device_unit.sv =====
`timescale 1ns / 1ps

// Cartridge slot device with a character ROM and two RAM packs, each in a
// single-port synchronous RAM. One request is taken every clock cycle unless
// the output stalls; its result passes the RAM read and result stage, then
// the output register. A pack write reads the old byte and writes the new one
// in the same RAM cycle, and the dirty flag is settled from the old byte in
// the result stage. The stores need no clearing after reset; an entry never
// preloaded or written reads back as anything.
module cartridge_slot_bank_device_unit #(
  parameter int PACK_ADDR_BITS = 16,
  parameter int ROM_ADDR_BITS  = 17
) (
  input  logic                       clk,
  input  logic                       rst,
  csbd_in_if.sink                    in_req,
  csbd_out_if.source                 out_rsp,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [csbd_pkg::PageBits-1:0] cfg_wdata
);
  import csbd_pkg::*;

  localparam int PackWide = (PACK_ADDR_BITS > 16) ? PACK_ADDR_BITS : 16;
  localparam int RomWide  = 24;

  logic [PageBits-1:0]       slot4_page;
  logic [PageBits-1:0]       slot3_page;
  logic [ModeBits-1:0]       slot_mode;
  logic [ROM_ADDR_BITS-1:0]  rom_pointer;
  logic [PACK_ADDR_BITS-1:0] pack_a_pointer;
  logic [PACK_ADDR_BITS-1:0] pack_b_pointer;
  logic                      pack_a_dirty;
  logic                      pack_b_dirty;

  logic                      s1_valid;
  src_t                      s1_src;
  logic [7:0]                s1_imm;
  logic                      s1_chk_a;
  logic                      s1_chk_b;
  logic                      s1_clr_a;
  logic                      s1_clr_b;
  logic [7:0]                s1_wbyte;
  logic                      s1_pv;
  logic                      s1_ps;
  logic [7:0]                s1_pp;

  in_item_t                  item;
  logic                      accept;
  logic                      s1_adv;

  src_t                      src_next;
  logic [7:0]                imm_next;
  logic                      chk_a_next;
  logic                      chk_b_next;
  logic                      clr_a_next;
  logic                      clr_b_next;
  logic                      pv_next;
  logic [ModeBits-1:0]       slot_mode_next;
  logic [ROM_ADDR_BITS-1:0]  rom_pointer_next;
  logic [PACK_ADDR_BITS-1:0] pack_a_pointer_next;
  logic [PACK_ADDR_BITS-1:0] pack_b_pointer_next;
  logic [RomWide-1:0]        rom_wide;
  logic [PackWide-1:0]       pack_a_wide;
  logic [PackWide-1:0]       pack_b_wide;
  logic [RomWide-1:0]        index_wide;

  logic                      we_a;
  logic                      we_b;
  logic                      we_rom;
  logic [PACK_ADDR_BITS-1:0] addr_a;
  logic [PACK_ADDR_BITS-1:0] addr_b;
  logic [ROM_ADDR_BITS-1:0]  addr_rom;
  logic [7:0]                rd_a;
  logic [7:0]                rd_b;
  logic [7:0]                rd_rom;
  logic [7:0]                result_byte;

  assign item   = in_req.payload;
  assign s1_adv = s1_valid && (!out_rsp.valid || out_rsp.ready);
  assign in_req.ready = !s1_valid || s1_adv;
  assign accept = in_req.valid && in_req.ready;

  // request decode
  always_comb begin
    src_next            = SRC_IMM;
    imm_next            = BYTE_IDLE;
    chk_a_next          = 1'b0;
    chk_b_next          = 1'b0;
    clr_a_next          = 1'b0;
    clr_b_next          = 1'b0;
    pv_next             = 1'b0;
    we_a                = 1'b0;
    we_b                = 1'b0;
    we_rom              = 1'b0;
    slot_mode_next      = slot_mode;
    rom_pointer_next    = rom_pointer;
    pack_a_pointer_next = pack_a_pointer;
    pack_b_pointer_next = pack_b_pointer;
    rom_wide            = RomWide'(rom_pointer);
    pack_a_wide         = PackWide'(pack_a_pointer);
    pack_b_wide         = PackWide'(pack_b_pointer);
    index_wide          = RomWide'(item.load_index);

    unique case (item.cmd)
      CMD_BUS_WRITE: begin
        if (item.port == PORT_MODE) begin
          if (!item.data[7]) begin
            slot_mode_next = item.data[ModeBits-1:0];
          end
        end else if (item.port == PORT_DATA) begin
          if (slot_mode == MODE_ROM) begin
            rom_wide[16 +: 8] = item.data;
            rom_pointer_next  = rom_wide[ROM_ADDR_BITS-1:0];
          end else if (slot_mode == MODE_PACK_B) begin
            we_b       = 1'b1;
            chk_b_next = 1'b1;
          end else if (slot_mode == MODE_PACK_A) begin
            we_a       = 1'b1;
            chk_a_next = 1'b1;
          end
        end else begin
          if (slot_mode == MODE_ROM) begin
            rom_wide[8*item.port[0] +: 8] = item.data;
            rom_pointer_next = rom_wide[ROM_ADDR_BITS-1:0];
          end else if (slot_mode == MODE_PACK_B) begin
            pack_b_wide[8*item.port[0] +: 8] = item.data;
            pack_b_pointer_next = pack_b_wide[PACK_ADDR_BITS-1:0];
          end else if (slot_mode == MODE_PACK_A) begin
            pack_a_wide[8*item.port[0] +: 8] = item.data;
            pack_a_pointer_next = pack_a_wide[PACK_ADDR_BITS-1:0];
          end else if (slot_mode == MODE_CONTROL) begin
            pv_next = 1'b1;
          end
        end
      end
      CMD_BUS_READ: begin
        case (slot_mode)
          MODE_JOYSTICK: begin
            if (item.port == PORT_DATA) begin
              imm_next = item.joystick;
            end
          end
          MODE_ROM:    src_next = SRC_ROM;
          MODE_PACK_B: src_next = SRC_PACK_B;
          MODE_PACK_A: src_next = SRC_PACK_A;
          MODE_CONTROL: begin
            case (item.port)
              PORT_LOW:  imm_next = 8'(slot4_page);
              PORT_MID:  imm_next = 8'(slot3_page);
              PORT_DATA: src_next = SRC_DIRTY;
              default:   imm_next = BYTE_IDLE;
            endcase
          end
          default: imm_next = BYTE_IDLE;
        endcase
      end
      CMD_PRELOAD: begin
        we_a   = (item.store_select == SEL_PACK_A);
        we_b   = (item.store_select == SEL_PACK_B);
        we_rom = (item.store_select == SEL_ROM);
      end
      CMD_SAVED: begin
        clr_a_next = (item.store_select == SEL_PACK_A);
        clr_b_next = (item.store_select == SEL_PACK_B);
      end
      default: begin
      end
    endcase
  end

  assign addr_a   = (item.cmd == CMD_PRELOAD) ? index_wide[PACK_ADDR_BITS-1:0]
                                              : pack_a_pointer;
  assign addr_b   = (item.cmd == CMD_PRELOAD) ? index_wide[PACK_ADDR_BITS-1:0]
                                              : pack_b_pointer;
  assign addr_rom = (item.cmd == CMD_PRELOAD) ? index_wide[ROM_ADDR_BITS-1:0]
                                              : rom_pointer;

  csbd_ram #(.ADDR_BITS(PACK_ADDR_BITS)) u_pack_a (
    .clk   (clk),
    .en    (accept),
    .we    (we_a),
    .addr  (addr_a),
    .wdata (item.data),
    .rdata (rd_a)
  );

  csbd_ram #(.ADDR_BITS(PACK_ADDR_BITS)) u_pack_b (
    .clk   (clk),
    .en    (accept),
    .we    (we_b),
    .addr  (addr_b),
    .wdata (item.data),
    .rdata (rd_b)
  );

  csbd_ram #(.ADDR_BITS(ROM_ADDR_BITS)) u_rom (
    .clk   (clk),
    .en    (accept),
    .we    (we_rom),
    .addr  (addr_rom),
    .wdata (item.data),
    .rdata (rd_rom)
  );

  // configuration and bus registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot4_page     <= '0;
      slot3_page     <= PageBits'(1);
      slot_mode      <= '0;
      rom_pointer    <= '0;
      pack_a_pointer <= '0;
      pack_b_pointer <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SLOT4_PAGE) begin
          slot4_page <= cfg_wdata;
        end else begin
          slot3_page <= cfg_wdata;
        end
      end
      if (accept) begin
        slot_mode      <= slot_mode_next;
        rom_pointer    <= rom_pointer_next;
        pack_a_pointer <= pack_a_pointer_next;
        pack_b_pointer <= pack_b_pointer_next;
      end
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src   <= src_next;
      s1_imm   <= imm_next;
      s1_chk_a <= chk_a_next;
      s1_chk_b <= chk_b_next;
      s1_clr_a <= clr_a_next;
      s1_clr_b <= clr_b_next;
      s1_wbyte <= item.data;
      s1_pv    <= pv_next;
      s1_ps    <= pv_next & item.port[0];
      s1_pp    <= pv_next ? item.data : 8'h00;
    end
  end

  // dirty flags are set when the old byte read back on a pack write differs, and cleared by a saved command
  always_ff @(posedge clk) begin
    if (rst) begin
      pack_a_dirty <= 1'b0;
      pack_b_dirty <= 1'b0;
    end else if (s1_adv) begin
      if (s1_clr_a) begin
        pack_a_dirty <= 1'b0;
      end else if (s1_chk_a && (rd_a != s1_wbyte)) begin
        pack_a_dirty <= 1'b1;
      end
      if (s1_clr_b) begin
        pack_b_dirty <= 1'b0;
      end else if (s1_chk_b && (rd_b != s1_wbyte)) begin
        pack_b_dirty <= 1'b1;
      end
    end
  end

  always_comb begin
    case (s1_src)
      SRC_ROM:    result_byte = rd_rom;
      SRC_PACK_A: result_byte = rd_a;
      SRC_PACK_B: result_byte = rd_b;
      SRC_DIRTY:  result_byte = {6'b0, pack_b_dirty, pack_a_dirty};
      default:    result_byte = s1_imm;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_rsp.valid <= 1'b0;
    end else if (s1_adv) begin
      out_rsp.valid <= 1'b1;
    end else if (out_rsp.ready) begin
      out_rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_rsp.payload.read_data          <= result_byte;
      out_rsp.payload.page_request_valid <= s1_pv;
      out_rsp.payload.page_request_slot  <= s1_ps;
      out_rsp.payload.page_request_page  <= s1_pp;
    end
  end

endmodule
